// ===== src/sdtks_pkg.sv =====
// shared constants and types for the stable descending top-k sorter
package sdtks_pkg;

    localparam int LIST_DEPTH  = 12;
    localparam int MAX_PLAYERS = 256;

    localparam int SLOT_W  = 8;
    localparam int SCORE_W = 16;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = $clog2(LIST_DEPTH + 1);

    // wide enough to hold the largest allowed player limit
    localparam int SLOT_CMP_W = 11;
    localparam logic [SLOT_CMP_W-1:0] MAX_PLAYERS_V = SLOT_CMP_W'(MAX_PLAYERS);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic emit;     // load the output register with the head entry
    } sdtks_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a new result
        logic final_entry;  // the next emitted result closes the run
    } sdtks_sts_t;

endpackage

// ===== src/sdtks_dp.sv =====
// datapath: row of compare-and-shift cells, rank counter and output register
module sdtks_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sdtks_pkg::sdtks_cmd_t                cmd,
    output sdtks_pkg::sdtks_sts_t                sts,
    input  logic [sdtks_pkg::SLOT_W-1:0]         in_slot,
    input  logic signed [sdtks_pkg::SCORE_W-1:0] in_score,
    input  logic                                 in_eligible,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [sdtks_pkg::RANK_W-1:0]         out_rank,
    output logic [sdtks_pkg::SLOT_W-1:0]         out_slot,
    output logic signed [sdtks_pkg::SCORE_W-1:0] out_score,
    output logic                                 out_entry_valid,
    output logic                                 out_last
);

    logic [sdtks_pkg::SLOT_W-1:0]         slot_reg  [sdtks_pkg::LIST_DEPTH];
    logic signed [sdtks_pkg::SCORE_W-1:0] score_reg [sdtks_pkg::LIST_DEPTH];
    logic [sdtks_pkg::COUNT_W-1:0]        count_reg;
    logic [sdtks_pkg::RANK_W-1:0]         rank_reg;
    logic                                 out_valid_reg;
    logic [sdtks_pkg::RANK_W-1:0]         out_rank_reg;
    logic [sdtks_pkg::SLOT_W-1:0]         out_slot_reg;
    logic signed [sdtks_pkg::SCORE_W-1:0] out_score_reg;
    logic                                 out_entry_valid_reg;
    logic                                 out_last_reg;

    logic [sdtks_pkg::LIST_DEPTH-1:0] ins_pos;
    logic                             slot_ok;
    logic                             do_insert;
    logic                             do_pop;
    logic                             list_full;
    logic                             list_empty;
    logic                             ordered;

    assign slot_ok    = ({(sdtks_pkg::SLOT_CMP_W - sdtks_pkg::SLOT_W)'(0), in_slot}
                         < sdtks_pkg::MAX_PLAYERS_V);
    assign list_full  = (count_reg == sdtks_pkg::COUNT_W'(sdtks_pkg::LIST_DEPTH));
    assign list_empty = (count_reg == '0);
    // ins_pos is monotone, so the last cell tells whether the record lands at all
    assign do_insert  = cmd.accept && in_eligible && slot_ok
                        && ins_pos[sdtks_pkg::LIST_DEPTH-1];
    assign do_pop     = cmd.emit && !list_empty;

    genvar i;
    generate
        for (i = 0; i < sdtks_pkg::LIST_DEPTH; i++) begin : g_cell
            // at or below the insert point: free cell or strictly lower score
            assign ins_pos[i] = (sdtks_pkg::COUNT_W'(i) >= count_reg)
                                || (in_score > score_reg[i]);

            if (i == 0) begin : g_head
                always_ff @(posedge aclk) begin
                    if (do_insert && ins_pos[i]) begin
                        slot_reg[i]  <= in_slot;
                        score_reg[i] <= in_score;
                    end else if (do_pop) begin
                        if (sdtks_pkg::LIST_DEPTH > 1) begin
                            slot_reg[i]  <= slot_reg[(i + 1) % sdtks_pkg::LIST_DEPTH];
                            score_reg[i] <= score_reg[(i + 1) % sdtks_pkg::LIST_DEPTH];
                        end else begin
                            slot_reg[i]  <= '0;
                            score_reg[i] <= '0;
                        end
                    end
                end
            end else begin : g_body
                always_ff @(posedge aclk) begin
                    if (do_insert && ins_pos[i]) begin
                        if (!ins_pos[i-1]) begin
                            slot_reg[i]  <= in_slot;
                            score_reg[i] <= in_score;
                        end else begin
                            slot_reg[i]  <= slot_reg[i-1];
                            score_reg[i] <= score_reg[i-1];
                        end
                    end else if (do_pop) begin
                        if (i == sdtks_pkg::LIST_DEPTH - 1) begin
                            slot_reg[i]  <= '0;
                            score_reg[i] <= '0;
                        end else begin
                            slot_reg[i]  <= slot_reg[(i + 1) % sdtks_pkg::LIST_DEPTH];
                            score_reg[i] <= score_reg[(i + 1) % sdtks_pkg::LIST_DEPTH];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (do_insert && !list_full) begin
            count_reg <= count_reg + 1'b1;
        end else if (do_pop) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= sdtks_pkg::RANK_W'(1);
        end else if (cmd.emit) begin
            if (sts.final_entry) begin
                rank_reg <= sdtks_pkg::RANK_W'(1);
            end else begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (list_empty) begin
                out_rank_reg        <= '0;
                out_slot_reg        <= '0;
                out_score_reg       <= '0;
                out_entry_valid_reg <= 1'b0;
                out_last_reg        <= 1'b1;
            end else begin
                out_rank_reg        <= rank_reg;
                out_slot_reg        <= slot_reg[0];
                out_score_reg       <= score_reg[0];
                out_entry_valid_reg <= 1'b1;
                out_last_reg        <= (count_reg == sdtks_pkg::COUNT_W'(1));
            end
        end
    end

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.final_entry = (count_reg <= sdtks_pkg::COUNT_W'(1));

    assign out_valid       = out_valid_reg;
    assign out_rank        = out_rank_reg;
    assign out_slot        = out_slot_reg;
    assign out_score       = out_score_reg;
    assign out_entry_valid = out_entry_valid_reg;
    assign out_last        = out_last_reg;

    // valid entries must stay in non-increasing score order
    always_comb begin
        ordered = 1'b1;
        for (int k = 0; k < sdtks_pkg::LIST_DEPTH - 1; k++) begin
            if ((sdtks_pkg::COUNT_W'(k + 1) < count_reg)
                && (score_reg[k] < score_reg[k+1])) begin
                ordered = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sdtks_pkg::COUNT_W'(sdtks_pkg::LIST_DEPTH))
        else $error("list count above depth");

    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        ordered)
        else $error("list lost descending order");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && cmd.emit))
        else $error("insert and emit in the same cycle");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.final_entry) |=> (count_reg == '0))
        else $error("list not empty after final result");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (out_last_reg == $past(sts.final_entry)))
        else $error("last flag does not match list end");

endmodule

// ===== src/sdtks_ctrl.sv =====
// controller: collects records, then drains the list one result per beat
module sdtks_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    input  sdtks_pkg::sdtks_sts_t sts,
    output sdtks_pkg::sdtks_cmd_t cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready   = (state_reg == ST_COLLECT);
    assign cmd.accept = in_valid && in_ready;
    assign cmd.emit   = (state_reg == ST_EMIT) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (cmd.accept && in_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.emit && sts.final_entry) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/stable_descending_top_k_sort.sv =====
// top level of the stable descending top-k score sorter
//
// records arrive on the s_ stream: slot and score in s_tdata, the eligible
// flag in s_tuser and the end of the set in s_tlast. every eligible record is
// inserted into a list of the best LIST_DEPTH (12) entries, kept
// in descending score with ties in arrival order. records stream in at one
// beat per cycle while the list is collecting.
// after the beat with s_tlast the input is held off (s_tready low) while the
// list drains on the m_ stream, one result per cycle while m_tready is high, head first: rank, slot
// and score in m_tdata, entry_valid in m_tuser, last result on m_tlast. after the
// last input beat the controller enters its emit state and then loads the first
// result into the output register. an empty list gives one result with m_tuser
// low. the list pops one entry per output beat, so a stall on m_tready just
// freezes the drain; input reopens once the final result is loaded and is taken
// again while that result waits.
// reset (aresetn low, synchronous) empties the list and drops any pending
// result.
module stable_descending_top_k_sort (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sdtks_pkg::IN_TDATA_W-1:0]     s_tdata,  // slot[7:0], score[23:8]
    input  logic                                 s_tuser,  // eligible
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sdtks_pkg::OUT_TDATA_W-1:0]    m_tdata,  // rank[3:0], slot[11:4],
                                                           // score[27:12], zero[31:28]
    output logic                                 m_tuser,  // entry_valid
    output logic                                 m_tlast
);

    sdtks_pkg::sdtks_cmd_t cmd;
    sdtks_pkg::sdtks_sts_t sts;

    logic [sdtks_pkg::RANK_W-1:0]         out_rank;
    logic [sdtks_pkg::SLOT_W-1:0]         out_slot;
    logic signed [sdtks_pkg::SCORE_W-1:0] out_score;

    sdtks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdtks_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_slot         (s_tdata[sdtks_pkg::SLOT_W-1:0]),
        .in_score        (s_tdata[sdtks_pkg::SLOT_W +: sdtks_pkg::SCORE_W]),
        .in_eligible     (s_tuser),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_rank        (out_rank),
        .out_slot        (out_slot),
        .out_score       (out_score),
        .out_entry_valid (m_tuser),
        .out_last        (m_tlast)
    );

    assign m_tdata = {
        (sdtks_pkg::OUT_TDATA_W - sdtks_pkg::RANK_W - sdtks_pkg::SLOT_W
         - sdtks_pkg::SCORE_W)'(0),
        out_score,
        out_slot,
        out_rank
    };

endmodule
